>>> rtl/npc_pkg.sv
package npc_pkg;

    localparam int NUM_COLORS = 16;
    localparam int IDX_W      = 4;
    localparam int COMP_W     = 8;
    localparam int SQ_W       = 2 * COMP_W;
    localparam int DIST_W     = 18;

    typedef struct packed {
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
    } rgb_t;

    typedef logic [NUM_COLORS-1:0][DIST_W-1:0] dist_vec_t;

    // fixed 16-color palette
    localparam rgb_t PALETTE [NUM_COLORS] = '{
        '{r: 8'd0,   g: 8'd0,   b: 8'd0  },
        '{r: 8'd255, g: 8'd145, b: 8'd72 },
        '{r: 8'd36,  g: 8'd218, b: 8'd36 },
        '{r: 8'd109, g: 8'd255, b: 8'd109},
        '{r: 8'd36,  g: 8'd35,  b: 8'd255},
        '{r: 8'd72,  g: 8'd109, b: 8'd255},
        '{r: 8'd182, g: 8'd36,  b: 8'd36 },
        '{r: 8'd72,  g: 8'd182, b: 8'd255},
        '{r: 8'd255, g: 8'd36,  b: 8'd36 },
        '{r: 8'd255, g: 8'd109, b: 8'd109},
        '{r: 8'd218, g: 8'd218, b: 8'd36 },
        '{r: 8'd218, g: 8'd218, b: 8'd145},
        '{r: 8'd36,  g: 8'd145, b: 8'd36 },
        '{r: 8'd218, g: 8'd72,  b: 8'd182},
        '{r: 8'd182, g: 8'd182, b: 8'd182},
        '{r: 8'd255, g: 8'd255, b: 8'd255}
    };

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

>>> rtl/nearest_palette_color.sv
// A word accepted at the input goes through the input reg, then the result reg,
//   before it can be taken at the output.
// Throughput: one word per cycle while the result is not stalled; the whole
//   distance/min path sits between the input register and the result register.
// in_ready drops only when both stages are full and the result is stalled.
// Reset (rst_n, async, active low) clears both valid flags; data regs are not reset.
module nearest_palette_color
    import npc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [COMP_W-1:0]   red_in,
    input  logic [COMP_W-1:0]   green_in,
    input  logic [COMP_W-1:0]   blue_in,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    palette_index,
    output logic [DIST_W-1:0]   min_distance
);

    // stage 1: registered pixel
    logic              s1_valid_reg;
    logic              s1_valid_next;
    rgb_t              pix_reg;
    rgb_t              pix_next;

    // stage 2: registered result word
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;

    dist_vec_t         dist_vec;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;

    logic              out_free;   // result reg can take a word this cycle
    logic              s1_move;    // stage 1 word moves to result reg
    logic              in_take;

    npc_dist u_dist
    (
        .pixel    (pix_reg),
        .dist_vec (dist_vec)
    );

    npc_min u_min
    (
        .dist_vec  (dist_vec),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        dist_next      = dist_reg;

        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_move)
        begin
            idx_next  = best_idx;
            dist_next = best_dist;
        end

        if (in_take)
        begin
            s1_valid_next = 1'b1;
            pix_next      = '{r: red_in, g: green_in, b: blue_in};
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload regs, no reset needed
    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        idx_reg  <= idx_next;
        dist_reg <= dist_next;
    end

    assign out_valid     = out_valid_reg;
    assign palette_index = idx_reg;
    assign min_distance  = dist_reg;

endmodule

>>> rtl/npc_dist.sv
module npc_dist
    import npc_pkg::*;
(
    input  rgb_t      pixel,
    output dist_vec_t dist_vec
);

    // one distance unit per palette entry, all in parallel
    always_comb
    begin
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            dist_vec[i] = DIST_W'(sq_diff(pixel.r, PALETTE[i].r))
                        + DIST_W'(sq_diff(pixel.g, PALETTE[i].g))
                        + DIST_W'(sq_diff(pixel.b, PALETTE[i].b));
        end
    end

endmodule

>>> rtl/npc_min.sv
module npc_min
    import npc_pkg::*;
(
    input  dist_vec_t         dist_vec,
    output logic [IDX_W-1:0]  best_idx,
    output logic [DIST_W-1:0] best_dist
);

    // 16 -> 8 -> 4 -> 2 -> 1 compare tree; left side (lower index) wins ties
    logic [DIST_W-1:0] d8 [8];
    logic [IDX_W-1:0]  i8 [8];
    logic [DIST_W-1:0] d4 [4];
    logic [IDX_W-1:0]  i4 [4];
    logic [DIST_W-1:0] d2 [2];
    logic [IDX_W-1:0]  i2 [2];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            if (dist_vec[2*k+1] < dist_vec[2*k])
            begin
                d8[k] = dist_vec[2*k+1];
                i8[k] = IDX_W'(2*k+1);
            end
            else
            begin
                d8[k] = dist_vec[2*k];
                i8[k] = IDX_W'(2*k);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (d8[2*k+1] < d8[2*k])
            begin
                d4[k] = d8[2*k+1];
                i4[k] = i8[2*k+1];
            end
            else
            begin
                d4[k] = d8[2*k];
                i4[k] = i8[2*k];
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            if (d4[2*k+1] < d4[2*k])
            begin
                d2[k] = d4[2*k+1];
                i2[k] = i4[2*k+1];
            end
            else
            begin
                d2[k] = d4[2*k];
                i2[k] = i4[2*k];
            end
        end
        if (d2[1] < d2[0])
        begin
            best_dist = d2[1];
            best_idx  = i2[1];
        end
        else
        begin
            best_dist = d2[0];
            best_idx  = i2[0];
        end
    end

endmodule

>>> rtl/npc_checker.sv
module npc_checker
    import npc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IDX_W-1:0]  palette_index,
    input logic [DIST_W-1:0] min_distance
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(palette_index)
            && $stable(min_distance))
        else $error("result word changed while stalled");

    // an empty output stage never backs up the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output stage");

    // input only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // an accepted word has a result presented once it has passed the input and result regs
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no result two cycles after accept");

endmodule

bind nearest_palette_color npc_checker u_npc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .palette_index (palette_index),
    .min_distance  (min_distance)
);

>>> sim/nearest_palette_color_tb.sv
`timescale 1ns / 100ps

// Testbench for nearest_palette_color.
// Every accepted pixel word is scored against a local copy of the 16-entry
// palette, and the expected (index, distance) pair is queued. Each result word
// taken at the output is compared field by field with the oldest entry.
module nearest_palette_color_tb;

    import npc_pkg::*;

    // expected result of one pixel word
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } match_t;

    // how the output side takes result words
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    localparam int HOLD_CYCLES  = 300;        // long output hold-off
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS   = 4_000_000;  // simulation timeout in ns

    // Palette kept locally so a wrong table entry in the RTL shows up.
    localparam rgb_t COLOR_TABLE [NUM_COLORS] = '{
        '{8'd0,   8'd0,   8'd0  },
        '{8'd255, 8'd145, 8'd72 },
        '{8'd36,  8'd218, 8'd36 },
        '{8'd109, 8'd255, 8'd109},
        '{8'd36,  8'd35,  8'd255},
        '{8'd72,  8'd109, 8'd255},
        '{8'd182, 8'd36,  8'd36 },
        '{8'd72,  8'd182, 8'd255},
        '{8'd255, 8'd36,  8'd36 },
        '{8'd255, 8'd109, 8'd109},
        '{8'd218, 8'd218, 8'd36 },
        '{8'd218, 8'd218, 8'd145},
        '{8'd36,  8'd145, 8'd36 },
        '{8'd218, 8'd72,  8'd182},
        '{8'd182, 8'd182, 8'd182},
        '{8'd255, 8'd255, 8'd255}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [COMP_W-1:0]   red_in;
    logic [COMP_W-1:0]   green_in;
    logic [COMP_W-1:0]   blue_in;
    logic                out_valid;
    logic                out_ready;
    logic [IDX_W-1:0]    palette_index;
    logic [DIST_W-1:0]   min_distance;

    match_t   pending_matches [$];   // expected results, oldest first
    match_t   want_m;
    int       err_count;
    int       burst_left;            // words left in the current sender burst
    bit       steady_tx;             // sender never idles while set
    rx_mode_t rx_mode;
    bit       hold_req;              // asks the output side for a long hold-off
    int       rx_phase;
    int       hold_cnt;

    nearest_palette_color dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .palette_index (palette_index),
        .min_distance  (min_distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Nearest palette entry by squared RGB distance; the first (lowest)
    // index is kept on a tie, so black wins whenever it is among the nearest.
    function automatic match_t nearest_entry(input logic [COMP_W-1:0] r,
                                             input logic [COMP_W-1:0] g,
                                             input logic [COMP_W-1:0] b);
        match_t m;
        int     dr;
        int     dg;
        int     db;
        int     d;
        m.index    = '0;
        m.distance = '0;
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            dr = int'(r) - int'(COLOR_TABLE[i].r);
            dg = int'(g) - int'(COLOR_TABLE[i].g);
            db = int'(b) - int'(COLOR_TABLE[i].b);
            d  = dr * dr + dg * dg + db * db;
            if (i == 0 || d < int'(m.distance))
            begin
                m.index    = IDX_W'(i);
                m.distance = DIST_W'(d);
            end
        end
        return m;
    endfunction

    function automatic logic [COMP_W-1:0] clamp8(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return COMP_W'(v);
    endfunction

    // Offers one pixel word and returns at the edge where it is taken.
    // Valid is left high so a following call keeps the stream going; an
    // idle gap, when due, comes before the word.
    task automatic send_pixel(input logic [COMP_W-1:0] r,
                              input logic [COMP_W-1:0] g,
                              input logic [COMP_W-1:0] b);
        int gap;
        if (!steady_tx && burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 5));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_matches.push_back(nearest_entry(r, g, b));
    endtask

    // Stops offering words and waits until every expected result is back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random pixel, biased toward palette entries and the points between
    // two of them, where ties and near-ties live.
    task automatic pick_pixel(output logic [COMP_W-1:0] r,
                              output logic [COMP_W-1:0] g,
                              output logic [COMP_W-1:0] b);
        int ka;
        int kb;
        int off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                r = COMP_W'($urandom_range(0, 255));
                g = COMP_W'($urandom_range(0, 255));
                b = COMP_W'($urandom_range(0, 255));
            end
            4, 5, 6:
            begin
                ka = $urandom_range(0, NUM_COLORS - 1);
                off = int'($urandom_range(0, 24)) - 12;
                r = clamp8(int'(COLOR_TABLE[ka].r) + off);
                off = int'($urandom_range(0, 24)) - 12;
                g = clamp8(int'(COLOR_TABLE[ka].g) + off);
                off = int'($urandom_range(0, 24)) - 12;
                b = clamp8(int'(COLOR_TABLE[ka].b) + off);
            end
            7, 8:
            begin
                ka = $urandom_range(0, NUM_COLORS - 1);
                kb = $urandom_range(0, NUM_COLORS - 1);
                off = int'($urandom_range(0, 2)) - 1;
                r = clamp8((int'(COLOR_TABLE[ka].r) + int'(COLOR_TABLE[kb].r)) / 2 + off);
                off = int'($urandom_range(0, 2)) - 1;
                g = clamp8((int'(COLOR_TABLE[ka].g) + int'(COLOR_TABLE[kb].g)) / 2 + off);
                off = int'($urandom_range(0, 2)) - 1;
                b = clamp8((int'(COLOR_TABLE[ka].b) + int'(COLOR_TABLE[kb].b)) / 2 + off);
            end
            default:
            begin
                // corners of the RGB cube mixed with random components
                r = ($urandom_range(0, 2) == 0) ? 8'd0 :
                    ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
                g = ($urandom_range(0, 2) == 0) ? 8'd0 :
                    ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
                b = ($urandom_range(0, 2) == 0) ? 8'd0 :
                    ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
            end
        endcase
    endtask

    // Each palette color exactly: distance zero, its own index.
    task automatic test_palette_exact();
        rx_mode = RX_PATTERN;
        for (int i = 0; i < NUM_COLORS; i++)
            send_pixel(COLOR_TABLE[i].r, COLOR_TABLE[i].g, COLOR_TABLE[i].b);
        drain();
    endtask

    // Primaries, mid gray, near-black, and two pixels equally far from
    // entries 4 and 5 (lower index must win).
    task automatic test_corners_and_ties();
        rx_mode = RX_RANDOM;
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd54,  8'd72,  8'd255);
        send_pixel(8'd17,  8'd90,  8'd255);
        send_pixel(8'd10,  8'd10,  8'd10);
        drain();
    endtask

    // Bursty sender, output side switching between its stall patterns.
    task automatic test_random_mixed(input int n);
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        steady_tx = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        drain();
    endtask

    // Back-to-back words with no stalls anywhere: full rate.
    task automatic test_steady_stream(input int n);
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        steady_tx = 1'b1;
        rx_mode   = RX_ALWAYS;
        for (int i = 0; i < n; i++)
        begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        drain();
        steady_tx = 1'b0;
    endtask

    // Output held off for a long stretch while the sender keeps pushing, so
    // both stages fill and in_ready has to drop; then release and go on.
    task automatic test_backpressure(input int n);
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        rx_mode   = RX_RANDOM;
        steady_tx = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                steady_tx = 1'b0;
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        drain();
    endtask

    // Output side: its own stall pattern, plus the long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        rx_phase  = 0;
        forever
        begin
            @(posedge clk);
            rx_phase++;
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: out_ready <= ((rx_phase % 11) < 6);
                    default:    out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Result check: every word taken at the output against the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("result word with nothing expected: palette_index %0d min_distance %0d",
                       palette_index, min_distance);
                err_count++;
            end
            else
            begin
                want_m = pending_matches.pop_front();
                if (palette_index !== want_m.index)
                begin
                    $error("palette_index mismatch: expected %0d, actual %0d",
                           want_m.index, palette_index);
                    err_count++;
                end
                if (min_distance !== want_m.distance)
                begin
                    $error("min_distance mismatch: expected %0d, actual %0d",
                           want_m.distance, min_distance);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        red_in     = '0;
        green_in   = '0;
        blue_in    = '0;
        err_count  = 0;
        burst_left = 0;
        steady_tx  = 1'b0;
        hold_req   = 1'b0;
        rx_mode    = RX_RANDOM;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_palette_exact();
        test_corners_and_ties();
        test_random_mixed(800);
        test_steady_stream(200);
        test_backpressure(125);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
